>>> sv/dvsb_pkg.sv
// Shared types, constants and helper functions for the seed-delta bitmap loader.
package dvsb_pkg;

	// Store geometry: one bit per seed, 64 seeds per word.
	localparam int SEED_BITS   = 20;
	localparam int WIDX_W      = SEED_BITS - 6;
	localparam int STORE_WORDS = 1 << WIDX_W;

	// File layout.
	localparam int LOOKAHEAD   = 4;
	localparam int PREFIX_END  = 24;
	localparam int PAD_POS     = 15;
	localparam int BYTES_W     = 5;

	// Varint group size and the saturated shift value.
	localparam int VAR_GROUP     = 7;
	localparam int VAR_SHIFT_MAX = 35;
	localparam int SHIFT_W       = 6;

	// Command queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_LOADED     = 2'd1,
		ST_BAD        = 2'd2,
		ST_NOT_LOADED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		LS_RECEIVING = 3'b001,
		LS_LOADED    = 3'b010,
		LS_BAD       = 3'b100
	} load_state_t;

	typedef enum logic [2:0] {
		CMD_RESULT       = 3'd0,
		CMD_WRITE        = 3'd1,
		CMD_WRITE_RESULT = 3'd2,
		CMD_READ_RESULT  = 3'd3,
		CMD_CLEAR_RESULT = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [WIDX_W-1:0] widx;
		logic [63:0]       wdata;
		logic [5:0]        bit_sel;
		status_t           status;
		logic [31:0]       seeds;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic clearing;
		logic clear_taken;
	} back_stat_t;

	// Expected header, pad and version bytes by file position.
	function automatic logic [7:0] prefix_byte(input logic [4:0] pos);
		logic [7:0] b;
		unique case (pos)
			5'd0:    b = 8'h53;
			5'd1:    b = 8'h45;
			5'd2:    b = 8'h45;
			5'd3:    b = 8'h44;
			5'd4:    b = 8'h5f;
			5'd5:    b = 8'h44;
			5'd6:    b = 8'h45;
			5'd7:    b = 8'h4c;
			5'd8:    b = 8'h54;
			5'd9:    b = 8'h41;
			5'd10:   b = 8'h5f;
			5'd11:   b = 8'h46;
			5'd12:   b = 8'h49;
			5'd13:   b = 8'h4c;
			5'd14:   b = 8'h45;
			5'd17:   b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// True when the seed has a bit in the store.
	function automatic logic seed_in_store(input logic [31:0] seed);
		return (({32'd0, seed} >> SEED_BITS) == 64'd0);
	endfunction

endpackage

>>> sv/dvsb_ram.sv
// Generic single-port RAM with registered read data.
module dvsb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first port: the read data is the old contents on a write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/dvsb_front.sv
// Front end: takes items, runs the file decoder and queues store commands.
module dvsb_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [1:0]              operation,
	input  logic [7:0]              file_byte,
	input  logic                    last_byte,
	input  logic [31:0]             query_seed,
	input  logic                    q_full,
	input  dvsb_pkg::back_stat_t    back_stat,
	output dvsb_pkg::push_t         push,
	output logic                    hold
);
	import dvsb_pkg::*;

	logic [7:0]         la_q [LOOKAHEAD];
	logic [7:0]         la_d [LOOKAHEAD];
	logic [BYTES_W-1:0] bytes_q, bytes_d;
	logic               prefix_ok_q, prefix_ok_d;
	logic [31:0]        acc_q, acc_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [31:0]        seed_q, seed_d;
	logic [31:0]        total_q, total_d;
	logic [63:0]        word_q, word_d;
	logic [WIDX_W-1:0]  widx_q, widx_d;
	load_state_t        ls_q, ls_d;
	logic               pend_q, pend_d;
	entry_t             pend_entry_q, pend_entry_d;
	logic               clear_wait_q, clear_wait_d;

	logic [7:0]         rel;
	logic [4:0]         pos;
	logic [31:0]        sh;
	logic [31:0]        seed_sum;
	logic [WIDX_W-1:0]  mark_idx;
	logic               flush_v;
	logic [31:0]        count;
	logic               file_ok;
	logic               new_valid;
	entry_t             new_entry;
	entry_t             flush_entry;
	entry_t             fin_entry;

	// Decoder next state and the command that the item puts in the queue.
	always_comb begin
		la_d         = la_q;
		bytes_d      = bytes_q;
		prefix_ok_d  = prefix_ok_q;
		acc_d        = acc_q;
		shift_d      = shift_q;
		seed_d       = seed_q;
		total_d      = total_q;
		word_d       = word_q;
		widx_d       = widx_q;
		ls_d         = ls_q;
		pend_d       = pend_q;
		pend_entry_d = pend_entry_q;
		clear_wait_d = clear_wait_q & ~back_stat.clear_taken;

		rel      = la_q[0];
		pos      = '0;
		sh       = '0;
		seed_sum = '0;
		mark_idx = '0;
		flush_v  = 1'b0;
		count    = '0;
		file_ok  = 1'b0;

		new_valid         = 1'b0;
		new_entry.cmd     = CMD_RESULT;
		new_entry.widx    = '0;
		new_entry.wdata   = '0;
		new_entry.bit_sel = '0;
		new_entry.status  = ST_ACCEPTED;
		new_entry.seeds   = total_q;
		flush_entry       = new_entry;
		fin_entry         = new_entry;

		// The second command of a split item leaves as soon as there is room.
		if (pend_q && !q_full) begin
			pend_d = 1'b0;
		end

		if (take) begin
			new_valid = 1'b1;
			unique case (op_t'(operation))
				OP_START: begin
					for (int i = 0; i < LOOKAHEAD; i++) begin
						la_d[i] = '0;
					end
					bytes_d         = '0;
					prefix_ok_d     = 1'b1;
					acc_d           = '0;
					shift_d         = '0;
					seed_d          = '0;
					total_d         = '0;
					word_d          = '0;
					widx_d          = '0;
					ls_d            = LS_RECEIVING;
					clear_wait_d    = 1'b1;
					new_entry.cmd   = CMD_CLEAR_RESULT;
					new_entry.seeds = '0;
				end
				OP_BYTE: begin
					if (ls_q != LS_RECEIVING) begin
						new_entry.status = ST_BAD;
					end else begin
						// The byte leaving the delay line is either prefix or varint data.
						if (bytes_q >= BYTES_W'(LOOKAHEAD)) begin
							if (bytes_q < BYTES_W'(PREFIX_END)) begin
								pos = bytes_q - BYTES_W'(LOOKAHEAD);
								if (pos != 5'(PAD_POS) && rel != prefix_byte(pos)) begin
									prefix_ok_d = 1'b0;
								end
							end else begin
								sh = shift_q[SHIFT_W-1] ? 32'd0 :
									(32'(rel[6:0]) << shift_q[4:0]);
								if (rel[7]) begin
									acc_d = acc_q | sh;
									shift_d = (shift_q >= SHIFT_W'(VAR_SHIFT_MAX - VAR_GROUP)) ?
										SHIFT_W'(VAR_SHIFT_MAX) : shift_q + SHIFT_W'(VAR_GROUP);
								end else begin
									seed_sum = seed_q + (acc_q | sh);
									seed_d   = seed_sum;
									total_d  = total_q + 32'd1;
									acc_d    = '0;
									shift_d  = '0;
									// Mark the seed; a new word index flushes the working word.
									if (!seed_in_store(seed_sum)) begin
										prefix_ok_d = 1'b0;
									end else begin
										mark_idx = seed_sum[SEED_BITS-1:6];
										flush_v  = (mark_idx != widx_q);
										word_d   = (flush_v ? 64'd0 : word_q) |
											(64'd1 << seed_sum[5:0]);
										widx_d   = mark_idx;
									end
								end
							end
						end
						la_d[0] = la_q[1];
						la_d[1] = la_q[2];
						la_d[2] = la_q[3];
						la_d[3] = file_byte;
						if (bytes_q < BYTES_W'(PREFIX_END)) begin
							bytes_d = bytes_q + BYTES_W'(1);
						end

						new_entry.seeds   = total_d;
						flush_entry.cmd   = CMD_WRITE_RESULT;
						flush_entry.widx  = widx_q;
						flush_entry.wdata = word_q;
						flush_entry.seeds = total_d;

						if (last_byte) begin
							// The incoming byte and the three newest delayed bytes hold the trailing count.
							count   = {file_byte, la_q[3], la_q[2], la_q[1]};
							file_ok = prefix_ok_d && (bytes_d >= BYTES_W'(PREFIX_END)) &&
								(shift_d == '0) && (count == total_d);
							ls_d    = file_ok ? LS_LOADED : LS_BAD;
							fin_entry.cmd    = CMD_WRITE_RESULT;
							fin_entry.widx   = widx_d;
							fin_entry.wdata  = word_d;
							fin_entry.status = file_ok ? ST_LOADED : ST_BAD;
							fin_entry.seeds  = total_d;
							if (flush_v) begin
								new_entry       = flush_entry;
								new_entry.cmd   = CMD_WRITE;
								pend_d          = 1'b1;
								pend_entry_d    = fin_entry;
							end else begin
								new_entry = fin_entry;
							end
						end else if (flush_v) begin
							new_entry = flush_entry;
						end
					end
				end
				OP_QUERY: begin
					if (ls_q != LS_LOADED) begin
						new_entry.status = ST_NOT_LOADED;
					end else if (seed_in_store(query_seed)) begin
						new_entry.cmd     = CMD_READ_RESULT;
						new_entry.widx    = query_seed[SEED_BITS-1:6];
						new_entry.bit_sel = query_seed[5:0];
					end
				end
				OP_NONE: begin
					new_entry.status = ST_ACCEPTED;
				end
			endcase
		end

		push.valid = pend_q ? !q_full : new_valid;
		push.entry = pend_q ? pend_entry_q : new_entry;
	end

	assign hold = pend_q || clear_wait_q;

	// Decoder and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOOKAHEAD; i++) begin
				la_q[i] <= '0;
			end
			bytes_q      <= '0;
			prefix_ok_q  <= 1'b1;
			acc_q        <= '0;
			shift_q      <= '0;
			seed_q       <= '0;
			total_q      <= '0;
			word_q       <= '0;
			widx_q       <= '0;
			ls_q         <= LS_RECEIVING;
			pend_q       <= 1'b0;
			clear_wait_q <= 1'b0;
		end else begin
			la_q         <= la_d;
			bytes_q      <= bytes_d;
			prefix_ok_q  <= prefix_ok_d;
			acc_q        <= acc_d;
			shift_q      <= shift_d;
			seed_q       <= seed_d;
			total_q      <= total_d;
			word_q       <= word_d;
			widx_q       <= widx_d;
			ls_q         <= ls_d;
			pend_q       <= pend_d;
			clear_wait_q <= clear_wait_d;
		end
	end

	// Held second command of a split item.
	always_ff @(posedge clk) begin
		pend_entry_q <= pend_entry_d;
	end

endmodule

>>> sv/dvsb_queue.sv
// Short command queue between the front end and the store back end.
module dvsb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  dvsb_pkg::push_t  push,
	input  logic             pop,
	output dvsb_pkg::entry_t head,
	output logic             full,
	output logic             empty
);
	import dvsb_pkg::*;

	entry_t            entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries_q[rd_q];

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_q] <= push.entry;
		end
	end

endmodule

>>> sv/dvsb_back.sv
// Back end: executes store writes, reads and clearing passes, and drives results.
module dvsb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dvsb_pkg::entry_t     head,
	input  logic                 empty,
	output logic                 pop,
	output dvsb_pkg::back_stat_t stat,
	output logic                 done,
	output logic [1:0]           status,
	output logic                 is_member,
	output logic [31:0]          seeds_decoded
);
	import dvsb_pkg::*;

	typedef enum logic [1:0] {
		BK_RUN   = 2'b01,
		BK_CLEAR = 2'b10
	} back_state_t;

	back_state_t       state_q, state_d;
	logic [WIDX_W-1:0] clr_addr_q, clr_addr_d;

	logic              ram_we;
	logic [WIDX_W-1:0] ram_addr;
	logic [63:0]       ram_wdata;
	logic [63:0]       ram_rdata;

	logic              valid_s1;
	logic              rd_s1;
	logic [5:0]        bit_s1;
	status_t           status_s1;
	logic [31:0]       seeds_s1;

	logic              done_q;
	logic [1:0]        status_q;
	logic              member_q;
	logic [31:0]       seeds_q;

	// Store port control: the clearing pass owns the port, otherwise the queue head does.
	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = head.widx;
		ram_wdata  = head.wdata;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we     = 1'b1;
				ram_addr   = clr_addr_q;
				ram_wdata  = '0;
				clr_addr_d = clr_addr_q + WIDX_W'(1);
				if (clr_addr_q == '1) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				pop = !empty;
				if (pop) begin
					priority case (head.cmd)
						CMD_WRITE, CMD_WRITE_RESULT: begin
							ram_we = 1'b1;
						end
						CMD_CLEAR_RESULT: begin
							state_d    = BK_CLEAR;
							clr_addr_d = '0;
						end
						default: begin
							ram_we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	assign stat.clearing    = (state_q == BK_CLEAR);
	assign stat.clear_taken = pop && (head.cmd == CMD_CLEAR_RESULT);

	dvsb_ram #(
		.WIDTH (64),
		.DEPTH (STORE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Control registers; reset starts a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			valid_s1   <= pop && (head.cmd != CMD_WRITE);
			done_q     <= valid_s1;
		end
	end

	// Result payload: stage 1 waits for the read data, then the output register.
	always_ff @(posedge clk) begin
		rd_s1     <= (head.cmd == CMD_READ_RESULT);
		bit_s1    <= head.bit_sel;
		status_s1 <= head.status;
		seeds_s1  <= head.seeds;
		status_q  <= status_s1;
		member_q  <= rd_s1 ? ram_rdata[bit_s1] : 1'b0;
		seeds_q   <= seeds_s1;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign is_member     = member_q;
	assign seeds_decoded = seeds_q;

endmodule

>>> sv/delta_varint_seed_bitmap_loader.sv
// Top level of the seed-delta bitmap loader: front end, command queue and store back end.
//
//   channel   ports                                               handshake
//   ------    -------------------------------------------------   ------------------------
//   item in   operation, file_byte, last_byte, query_seed          start && !busy
//   result    status, is_member, seeds_decoded                     done, one cycle, no stall
//
// File bytes, queries and unused operations can be taken back to back while busy is low; a
// last byte whose final word flush meets a word change queues two store writes and holds
// busy until the second is queued. Results leave in item order, through the queue, the
// store port with its registered read and the done register. Reset and every start item run
// a clearing pass over all STORE_WORDS words of the store (16384 at 20 seed bits), with busy
// high throughout. A full command queue also raises busy; the result side never stalls.
module delta_varint_seed_bitmap_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  file_byte,
	input  logic        last_byte,
	input  logic [31:0] query_seed,
	output logic        done,
	output logic [1:0]  status,
	output logic        is_member,
	output logic [31:0] seeds_decoded
);
	import dvsb_pkg::*;

	logic       take;
	logic       front_hold;
	logic       q_full;
	logic       q_empty;
	logic       back_pop;
	push_t      q_push;
	entry_t     q_head;
	back_stat_t back_stat;

	// Items are held off while the queue is full, a split item is pending or a clearing pass is pending or running.
	assign busy = q_full || front_hold || back_stat.clearing;
	assign take = start && !busy;

	dvsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.operation  (operation),
		.file_byte  (file_byte),
		.last_byte  (last_byte),
		.query_seed (query_seed),
		.q_full     (q_full),
		.back_stat  (back_stat),
		.push       (q_push),
		.hold       (front_hold)
	);

	dvsb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (back_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	dvsb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (back_pop),
		.stat          (back_stat),
		.done          (done),
		.status        (status),
		.is_member     (is_member),
		.seeds_decoded (seeds_decoded)
	);

`ifndef ASSERT_OFF
	// The front end never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push.valid)
		else $error("command pushed into a full queue");

	// A start item keeps further items out until its clearing pass is over.
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && (operation == OP_START)) |=> busy)
		else $error("item accepted right after a start");

	// A membership hit only comes with an accepted status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_member) |-> (status == ST_ACCEPTED))
		else $error("membership reported with a non-accepted status");
`endif

endmodule

>>> sim/delta_varint_seed_bitmap_loader_tb.sv
// Self-checking testbench for the seed-delta bitmap loader: random cache files, queries, checks.
`timescale 1ns / 100ps

module delta_varint_seed_bitmap_loader_tb;
	import dvsb_pkg::*;

	localparam int      IDLE_PCT    = 38;
	localparam int      ITEM_TARGET = 1700;
	localparam longint  CYCLE_LIMIT = 2_000_000;
	localparam longint  SEED_SPAN   = 64'd1 << SEED_BITS;
	// ASCII header text, first character in the top byte.
	localparam logic [8*15-1:0] HEADER       = 120'h53_45_45_44_5f_44_45_4c_54_41_5f_46_49_4c_45;
	localparam logic [31:0]     FILE_VERSION = 32'h0000_0100;
	localparam logic [31:0]     LIMIT_SEEDS [5] = '{32'd0, 32'(SEED_SPAN - 1), 32'(SEED_SPAN),
		32'h7fff_ffff, 32'hffff_ffff};

	// Kinds of generated file.
	localparam int V_GOOD       = 0;
	localparam int V_BAD_HEADER = 1;
	localparam int V_BAD_VER    = 2;
	localparam int V_UNFINISHED = 3;
	localparam int V_BAD_COUNT  = 4;
	localparam int V_BEYOND     = 5;
	localparam int V_SHORT      = 6;
	localparam int V_NOISE      = 7;
	localparam int V_NO_START   = 8;

	typedef struct packed {
		op_t         op;
		logic [7:0]  fbyte;
		logic        last;
		logic [31:0] qseed;
		logic        hold;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        member;
		logic [31:0] seeds;
	} result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = OP_NONE;
	logic [7:0]  file_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic [31:0] query_seed = 32'd0;
	logic        done;
	logic [1:0]  status;
	logic        is_member;
	logic [31:0] seeds_decoded;

	item_t   pending_items [$];
	result_t expected_results [$];
	int      issued_count, taken_count, counted_items, checked_count, errors;
	int      files_loaded, files_rejected, member_hits;
	longint  cycles;

	// Model of the loader state.
	logic [7:0]        window [4];
	int                seen;
	bit                file_ok;
	logic [31:0]       acc;
	int                vshift;
	logic [31:0]       run_seed;
	logic [31:0]       total;
	logic [63:0]       work_word;
	logic [WIDX_W-1:0] word_idx;
	logic [63:0]       store_model [STORE_WORDS];
	load_state_t       ld_state;

	delta_varint_seed_bitmap_loader u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.file_byte     (file_byte),
		.last_byte     (last_byte),
		.query_seed    (query_seed),
		.done          (done),
		.status        (status),
		.is_member     (is_member),
		.seeds_decoded (seeds_decoded)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected header, pad and version byte at a file position; the pad is never compared.
	function automatic logic [7:0] prefix_at(input int pos);
		if (pos < PAD_POS)
			return HEADER[8*(PAD_POS-1-pos) +: 8];
		if (pos > PAD_POS)
			return FILE_VERSION[8*(pos-PAD_POS-1) +: 8];
		return 8'd0;
	endfunction

	function automatic void wipe_model();
		for (int i = 0; i < LOOKAHEAD; i++)
			window[i] = 8'd0;
		seen = 0;
		file_ok = 1'b1;
		acc = '0;
		vshift = 0;
		run_seed = '0;
		total = '0;
		work_word = '0;
		word_idx = '0;
		for (int i = 0; i < STORE_WORDS; i++)
			store_model[i] = '0;
		ld_state = LS_RECEIVING;
	endfunction

	// Applies one accepted item to the model and returns the answer it should give.
	function automatic result_t loader_step(input item_t it);
		result_t           r;
		logic [7:0]        rel;
		logic [31:0]       delta;
		logic [31:0]       cnt;
		logic [63:0]       wide;
		logic [WIDX_W-1:0] widx;
		bit                ok;
		r.status = ST_ACCEPTED;
		r.member = 1'b0;
		case (it.op)
			OP_START: wipe_model();
			OP_BYTE: begin
				if (ld_state != LS_RECEIVING) begin
					r.status = ST_BAD;
				end else begin
					// The byte leaving the delay line is either prefix or delta data.
					if (seen >= LOOKAHEAD) begin
						rel = window[0];
						if (seen < PREFIX_END) begin
							if (seen - LOOKAHEAD != PAD_POS && rel != prefix_at(seen - LOOKAHEAD))
								file_ok = 1'b0;
						end else if (rel[7]) begin
							wide = {57'd0, rel[6:0]} << vshift;
							if (vshift < 32)
								acc |= wide[31:0];
							vshift = (vshift + VAR_GROUP > VAR_SHIFT_MAX) ? VAR_SHIFT_MAX
								: vshift + VAR_GROUP;
						end else begin
							wide = {56'd0, rel} << vshift;
							delta = acc;
							if (vshift < 32)
								delta |= wide[31:0];
							run_seed += delta;
							total += 1;
							acc = '0;
							vshift = 0;
							// Mark the seed; a new word index flushes the working word over the entry.
							if (run_seed[31:SEED_BITS] != '0) begin
								file_ok = 1'b0;
							end else begin
								widx = run_seed[SEED_BITS-1:6];
								if (widx != word_idx) begin
									store_model[word_idx] = work_word;
									work_word = '0;
									word_idx = widx;
								end
								work_word[run_seed[5:0]] = 1'b1;
							end
						end
					end
					window[0] = window[1];
					window[1] = window[2];
					window[2] = window[3];
					window[3] = it.fbyte;
					if (seen < PREFIX_END)
						seen++;
					// The last four bytes left in the delay line hold the count.
					if (it.last) begin
						cnt = {window[3], window[2], window[1], window[0]};
						store_model[word_idx] = work_word;
						ok = file_ok && seen >= PREFIX_END && vshift == 0 && cnt == total;
						ld_state = ok ? LS_LOADED : LS_BAD;
						r.status = ok ? ST_LOADED : ST_BAD;
						if (ok)
							files_loaded++;
						else
							files_rejected++;
					end
				end
			end
			OP_QUERY: begin
				if (ld_state != LS_LOADED)
					r.status = ST_NOT_LOADED;
				else if (it.qseed[31:SEED_BITS] == '0)
					r.member = store_model[it.qseed[SEED_BITS-1:6]][it.qseed[5:0]];
				member_hits += r.member;
			end
			default: ;
		endcase
		r.seeds = total;
		return r;
	endfunction

	task automatic add_item(input op_t op, input logic [7:0] fb, input logic lb,
			input logic [31:0] qs);
		item_t it;
		it.op = op;
		it.fbyte = fb;
		it.last = lb;
		it.qseed = qs;
		it.hold = 1'b0;
		pending_items = {pending_items, it};
		if (op != OP_NONE)
			counted_items++;
	endtask

	// Stimulus: a directed opening, then random cache files each followed by queries.
	initial begin : stimulus
		int          variant, n_deltas, pad, cut, n_q, k, r, files;
		logic [31:0] run, delta, v, count, qs;
		logic [7:0]  b;
		logic [7:0]  fbytes [$];
		logic [31:0] marked [$];
		item_t       pause;

		wipe_model();
		pause = '0;
		pause.hold = 1'b1;

		// Directed part: unused operation, queries before a load, short file, byte after end.
		add_item(OP_NONE, 8'hff, 1'b1, 32'hffff_ffff);
		add_item(OP_QUERY, 8'h00, 1'b0, 32'd0);
		add_item(OP_QUERY, 8'hff, 1'b1, 32'hffff_ffff);
		add_item(OP_START, 8'h00, 1'b1, 32'd0);
		add_item(OP_BYTE, 8'hff, 1'b0, 32'd0);
		add_item(OP_BYTE, 8'h00, 1'b0, 32'hffff_ffff);
		add_item(OP_BYTE, 8'h53, 1'b1, 32'd0);
		add_item(OP_BYTE, 8'hff, 1'b1, 32'd0);
		add_item(OP_QUERY, 8'h00, 1'b0, 32'hffff_ffff);
		add_item(OP_NONE, 8'h00, 1'b0, 32'd0);

		files = 0;
		while (counted_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			variant = (r < 50) ? V_GOOD : (r < 57) ? V_BAD_HEADER : (r < 62) ? V_BAD_VER
				: (r < 68) ? V_UNFINISHED : (r < 74) ? V_BAD_COUNT : (r < 80) ? V_BEYOND
				: (r < 86) ? V_SHORT : (r < 95) ? V_NOISE : V_NO_START;
			fbytes.delete();
			marked.delete();
			run = '0;

			// Header, pad and version, optionally damaged.
			for (k = 0; k < PREFIX_END - LOOKAHEAD; k++)
				fbytes = {fbytes, (k == PAD_POS) ? 8'($urandom) : prefix_at(k)};
			if (variant == V_BAD_HEADER)
				fbytes[$urandom_range(0, PAD_POS - 1)] ^= 8'($urandom_range(1, 255));
			if (variant == V_BAD_VER)
				fbytes[$urandom_range(PAD_POS + 1, PREFIX_END - LOOKAHEAD - 1)] ^=
					8'($urandom_range(1, 255));

			// Deltas: mostly small steps, with repeats, wraps back to low words and top-word jumps.
			n_deltas = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 45);
			if (variant == V_BEYOND && n_deltas == 0)
				n_deltas = 3;
			for (k = 0; k < n_deltas; k++) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					delta = 0;
				else if (r < 15)
					delta = $urandom_range(1, 200);
				else if (r < 18)
					delta = $urandom_range(201, 5000);
				else if (r == 18)
					delta = $urandom_range(0, 300) - run;
				else if (k == n_deltas - 1 && run < SEED_SPAN - 64)
					delta = 32'(SEED_SPAN - 64 - run) + $urandom_range(0, 63);
				else
					delta = $urandom_range(1, 200);
				if (variant == V_BEYOND && k == n_deltas / 2)
					delta = ($urandom_range(0, 1) ? 32'(SEED_SPAN - run) + $urandom_range(0, 1000)
						: $urandom);
				run += delta;
				if (run < SEED_SPAN)
					marked = {marked, run};
				// Seven-bit groups, low first; some carry extra empty groups after the last significant one.
				pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
				v = delta;
				do begin
					b = {1'b0, v[6:0]};
					v = v >> VAR_GROUP;
					if (v != 0 || pad > 0)
						b[7] = 1'b1;
					fbytes = {fbytes, b};
				end while (v != 0);
				while (pad > 0) begin
					pad--;
					fbytes = {fbytes, (pad > 0) ? 8'h80 : 8'h00};
				end
			end
			if (variant == V_UNFINISHED)
				fbytes = {fbytes, {1'b1, 7'($urandom)}};
			count = n_deltas;
			if (variant == V_BAD_COUNT)
				count ^= 32'd1 << $urandom_range(0, 31);
			for (k = 0; k < 4; k++)
				fbytes = {fbytes, count[8*k +: 8]};

			if (variant == V_SHORT) begin
				cut = $urandom_range(1, PREFIX_END - 1);
				while (fbytes.size() > cut)
					void'(fbytes.pop_back());
			end
			if (variant == V_NOISE) begin
				cut = $urandom_range(PREFIX_END, 60);
				if ($urandom_range(0, 1))
					fbytes.delete();
				else
					while (fbytes.size() > PREFIX_END - LOOKAHEAD)
						void'(fbytes.pop_back());
				while (fbytes.size() < cut)
					fbytes = {fbytes, 8'($urandom)};
			end

			// Send the file, with the odd stray query or unused operation mixed in.
			if (variant != V_NO_START)
				add_item(OP_START, 8'($urandom), 1'($urandom), $urandom);
			for (k = 0; k < fbytes.size(); k++) begin
				if ($urandom_range(0, 29) == 0)
					add_item($urandom_range(0, 1) ? OP_QUERY : OP_NONE, 8'($urandom),
						1'($urandom), $urandom);
				add_item(OP_BYTE, fbytes[k], k == fbytes.size() - 1, $urandom);
			end

			// Sometimes let the loader drain completely before querying.
			if (files == 0 || $urandom_range(0, 3) == 0)
				pending_items = {pending_items, pause};
			files++;

			n_q = $urandom_range(5, 25);
			for (k = 0; k < n_q; k++) begin
				r = $urandom_range(0, 9);
				if (r <= 4 && marked.size() != 0)
					qs = marked[$urandom_range(0, marked.size() - 1)] + (r == 4);
				else if (r <= 6)
					qs = $urandom_range(0, 32'(SEED_SPAN - 1));
				else if (r == 7)
					qs = $urandom;
				else if (r == 8)
					qs = LIMIT_SEEDS[$urandom_range(0, 4)];
				if (r == 9)
					add_item($urandom_range(0, 1) ? OP_BYTE : OP_NONE, 8'($urandom),
						1'($urandom), $urandom);
				else
					add_item(OP_QUERY, 8'($urandom), 1'($urandom), qs);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_items.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);

		$display("Checked %0d results from %0d items over %0d files (%0d loaded, %0d rejected).",
			checked_count, taken_count, files + 1, files_loaded, files_rejected);
		$display("Queries found %0d seeds present in the store.", member_hits);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Driver: offers the next item at the falling edge once the previous one was taken.
	always @(negedge clk) begin : driver
		item_t nxt;
		bit    go;
		bit    calm;
		if (arst_n && !(start && taken_count != issued_count)) begin
			go = 1'b0;
			calm = issued_count >= 400 && issued_count < 700;
			if (pending_items.size() != 0 && pending_items[0].hold &&
					expected_results.size() == 0)
				void'(pending_items.pop_front());
			if (pending_items.size() != 0 && !pending_items[0].hold &&
					(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = pending_items.pop_front();
				go = 1'b1;
				issued_count++;
				operation <= nxt.op;
				file_byte <= nxt.fbyte;
				last_byte <= nxt.last;
				query_seed <= nxt.qseed;
			end
			start <= go;
		end
	end

	// Monitor: predicts on every accepted item and checks every result in order.
	always @(posedge clk) begin : monitor
		item_t   it;
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				it.op = op_t'(operation);
				it.fbyte = file_byte;
				it.last = last_byte;
				it.qseed = query_seed;
				it.hold = 1'b0;
				want = loader_step(it);
				expected_results = {expected_results, want};
				taken_count++;
			end
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no item outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (is_member !== want.member) begin
						$error("is_member: expected %0d, got %0d", want.member, is_member);
						errors++;
					end
					if (seeds_decoded !== want.seeds) begin
						$error("seeds_decoded: expected %0d, got %0d", want.seeds, seeds_decoded);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

>>> files.f
sv/dvsb_pkg.sv
sv/dvsb_ram.sv
sv/dvsb_front.sv
sv/dvsb_queue.sv
sv/dvsb_back.sv
sv/delta_varint_seed_bitmap_loader.sv
sim/delta_varint_seed_bitmap_loader_tb.sv
